>>> src/sixdb_pkg.sv
`timescale 1ns / 1ps
// sixdb_pkg: shared types and constants for the six-input debouncer with stuck detection.
// No dependencies.
package sixdb_pkg;

  localparam int FIELD_W     = 6;
  localparam int REPORT_CH   = 4;
  localparam int CONFIRM_W   = 8;
  localparam int ERROR_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0]  CFG_CONFIRM_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_ERROR_LIMIT   = 1'd1;

  localparam logic [CONFIRM_W-1:0]  CONFIRM_RESET = 8'd10;
  localparam logic [ERROR_W-1:0]    ERROR_RESET   = 16'd5000;

  typedef struct packed {
    logic level;
    logic err;
    logic rise;
    logic fall;
  } lane_flags_t;

  typedef struct packed {
    logic [FIELD_W-1:0] stable_levels;
    logic [FIELD_W-1:0] error_flags;
    logic [FIELD_W-1:0] rise_flags;
    logic [FIELD_W-1:0] fall_flags;
    logic               report_request;
  } result_t;

endpackage

>>> src/sixdb_lane.sv
`timescale 1ns / 1ps
// sixdb_lane: one debounce channel with a saturating high-duration counter.
// Depends on sixdb_pkg.
module sixdb_lane #(
  parameter int DURATION_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                sample,
  input  logic [sixdb_pkg::CONFIRM_W-1:0]     confirm_limit,
  input  logic [DURATION_WIDTH-1:0]           cap,
  output sixdb_pkg::lane_flags_t              flags
);
  import sixdb_pkg::*;

  logic                      lvl_r, lvl_nxt;
  logic                      pend_r, pend_nxt;
  logic [CONFIRM_W-1:0]      cnt_r, cnt_nxt;
  logic [DURATION_WIDTH-1:0] hd_r, hd_nxt;
  logic                      pend_tmp;
  logic [CONFIRM_W:0]        cnt_inc;
  logic [DURATION_WIDTH:0]   hd_inc;

  always_comb begin
    lvl_nxt   = lvl_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    hd_nxt    = hd_r;
    flags     = '0;
    pend_tmp  = pend_r;
    if ((lvl_r != sample) && (cnt_r == '0)) begin
      pend_tmp = sample;
    end
    cnt_inc = {1'b0, cnt_r} + 1'b1;
    hd_inc  = {1'b0, hd_r} + 1'b1;
    if ((pend_tmp == sample) && (pend_tmp != lvl_r)) begin
      pend_nxt = pend_tmp;
      if (cnt_inc > {1'b0, confirm_limit}) begin
        lvl_nxt = pend_tmp;
        cnt_nxt = '0;
        if (pend_tmp) begin
          flags.rise = 1'b1;
        end else begin
          flags.fall = 1'b1;
          hd_nxt     = '0;
        end
      end else begin
        cnt_nxt = cnt_inc[CONFIRM_W-1:0];
      end
    end else begin
      pend_nxt = lvl_r;
      cnt_nxt  = '0;
    end
    if (lvl_nxt) begin
      flags.level = 1'b1;
      if (hd_inc >= {1'b0, cap}) begin
        hd_nxt    = cap;
        flags.err = 1'b1;
      end else begin
        hd_nxt = hd_inc[DURATION_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r  <= 1'b0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
      hd_r   <= '0;
    end else if (adv) begin
      lvl_r  <= lvl_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      hd_r   <= hd_nxt;
    end
  end

  a_cnt_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (pend_r != lvl_r))
    else $error("mismatch count running without a pending change");

  a_err_high: assert property (@(posedge clk) disable iff (!rst_n)
    flags.err |-> flags.level)
    else $error("stuck flag on a low channel");

  a_fall_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && flags.fall) |=> (hd_r == '0) && !lvl_r)
    else $error("fall did not clear duration counter");

endmodule

>>> src/sixdb_merge.sv
`timescale 1ns / 1ps
// sixdb_merge: packs lane flags into one result and holds it in an output register with skid.
// Depends on sixdb_pkg.
module sixdb_merge #(
  parameter int CHANNELS = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   acc,
  input  sixdb_pkg::lane_flags_t lane_flags [CHANNELS],
  output logic                   out_valid,
  input  logic                   out_stall,
  output sixdb_pkg::result_t     out_data
);
  import sixdb_pkg::*;

  result_t res;
  result_t out_r, skid_r;
  logic    out_vld_r, skid_vld_r;
  logic    out_take;

  always_comb begin
    res = '0;
    for (int j = 0; j < FIELD_W; j++) begin
      if (j < CHANNELS) begin
        res.stable_levels[j] = lane_flags[j].level;
        res.error_flags[j]   = lane_flags[j].err;
        res.rise_flags[j]    = lane_flags[j].rise;
        res.fall_flags[j]    = lane_flags[j].fall;
      end
    end
    res.report_request = |res.rise_flags[REPORT_CH-1:0];
  end

  assign in_stall  = skid_vld_r;
  assign acc       = in_valid && !skid_vld_r;
  assign out_take  = out_vld_r && !out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (acc) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (acc) begin
      if (!out_vld_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a result while output register is empty");

  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.report_request == (|out_r.rise_flags[REPORT_CH-1:0])))
    else $error("report request disagrees with rise flags");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !skid_vld_r && !acc) |=> !out_vld_r)
    else $error("output register kept a transferred result");

endmodule

>>> src/six_input_debouncer_stuck_detect_unit.sv
`timescale 1ns / 1ps
// six_input_debouncer_stuck_detect_unit: top level, config registers, debounce lanes, merge.
// Depends on sixdb_pkg, sixdb_lane, sixdb_merge.
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+------------------------
//  input   | in_valid, in_stall, in_raw_inputs       | in_valid && !in_stall
//  result  | out_valid, out_stall, out_* fields      | out_valid && !out_stall
//  config  | cfg_wr_en, cfg_index, cfg_wdata         | cfg_wr_en
//
// One sample per clock while in_stall is low; each result is registered at the output.
// All lanes update their counters in the transfer cycle; the output register
// plus a one-entry skid buffer keep input flowing while a result waits.
// in_stall rises only when both output entries are full.
// Synchronous reset clears all lane state and loads default limits.
module six_input_debouncer_stuck_detect_unit #(
  parameter int CHANNELS       = 6,
  parameter int DURATION_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sixdb_pkg::FIELD_W-1:0]        in_raw_inputs,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sixdb_pkg::FIELD_W-1:0]        out_stable_levels,
  output logic [sixdb_pkg::FIELD_W-1:0]        out_error_flags,
  output logic [sixdb_pkg::FIELD_W-1:0]        out_rise_flags,
  output logic [sixdb_pkg::FIELD_W-1:0]        out_fall_flags,
  output logic                                 out_report_request,
  input  logic                                 cfg_wr_en,
  input  logic [sixdb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sixdb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sixdb_pkg::*;

  localparam int CAP_W = (DURATION_WIDTH > ERROR_W) ? DURATION_WIDTH : ERROR_W;

  logic [CONFIRM_W-1:0]      confirm_limit_r;
  logic [ERROR_W-1:0]        error_limit_r;
  logic [CAP_W-1:0]          limit_ext;
  logic [CAP_W-1:0]          max_ext;
  logic [DURATION_WIDTH-1:0] cap;
  logic                      acc;
  lane_flags_t               lane_flags [CHANNELS];
  result_t                   out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_limit_r <= CONFIRM_RESET;
      error_limit_r   <= ERROR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CONFIRM_LIMIT: confirm_limit_r <= cfg_wdata[CONFIRM_W-1:0];
        CFG_ERROR_LIMIT:   error_limit_r   <= cfg_wdata[ERROR_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit_ext = CAP_W'(error_limit_r);
  assign max_ext   = CAP_W'({DURATION_WIDTH{1'b1}});
  assign cap       = (limit_ext > max_ext) ? DURATION_WIDTH'(max_ext)
                                           : DURATION_WIDTH'(limit_ext);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic sample;
    if (i < FIELD_W) begin : g_pin
      assign sample = in_raw_inputs[i];
    end else begin : g_tie
      assign sample = 1'b0;
    end
    sixdb_lane #(
      .DURATION_WIDTH(DURATION_WIDTH)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (acc),
      .sample       (sample),
      .confirm_limit(confirm_limit_r),
      .cap          (cap),
      .flags        (lane_flags[i])
    );
  end

  sixdb_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .acc       (acc),
    .lane_flags(lane_flags),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_stable_levels  = out_data.stable_levels;
  assign out_error_flags    = out_data.error_flags;
  assign out_rise_flags     = out_data.rise_flags;
  assign out_fall_flags     = out_data.fall_flags;
  assign out_report_request = out_data.report_request;

endmodule
